FILE: hdl/rad_pkg.sv
package rad_pkg;

    localparam int ACC_W   = 32;
    localparam int CNT_W   = 12;
    localparam int COORD_W = 16;
    localparam int DIM_W   = 13;
    localparam int IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_START_X    = 3'd0,
        REG_START_Y    = 3'd1,
        REG_ROW_STEP_X = 3'd2,
        REG_ROW_STEP_Y = 3'd3,
        REG_COL_STEP_X = 3'd4,
        REG_COL_STEP_Y = 3'd5,
        REG_DEST_WIDTH = 3'd6,
        REG_DEST_HEIGHT = 3'd7
    } cfg_index_t;

    // Settings as the datapath sees them: start already clamped, sizes as last index
    typedef struct packed {
        logic [ACC_W-1:0] start_x;
        logic [ACC_W-1:0] start_y;
        logic [ACC_W-1:0] row_step_x;
        logic [ACC_W-1:0] row_step_y;
        logic [ACC_W-1:0] col_step_x;
        logic [ACC_W-1:0] col_step_y;
        logic [CNT_W-1:0] col_last;
        logic [CNT_W-1:0] row_last;
    } cfg_t;

endpackage

FILE: hdl/rad_cfg_regs.sv
module rad_cfg_regs
    import rad_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [ACC_W-1:0] wr_data,
    output cfg_t             cfg
);

    localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

    // Reset sizes are 640 by 480, limited to MAX_DIM like any written size
    localparam logic [CNT_W-1:0] ColLastRst = CNT_W'(((MAX_DIM < 640) ? MAX_DIM : 640) - 1);
    localparam logic [CNT_W-1:0] RowLastRst = CNT_W'(((MAX_DIM < 480) ? MAX_DIM : 480) - 1);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [ACC_W-1:0] start_clamped;
    logic [DIM_W-1:0] dim_raw;
    logic [DIM_W-1:0] dim_eff;
    logic [CNT_W-1:0] dim_last;

    assign start_clamped = wr_data[ACC_W-1] ? '0 : wr_data;
    assign dim_raw       = wr_data[DIM_W-1:0];

    // Zero counts as one, anything past the limit as the limit; keep last index
    always_comb
    begin
        if (dim_raw == '0)
        begin
            dim_eff = DIM_W'(1);
        end
        else if (dim_raw > MaxDim)
        begin
            dim_eff = MaxDim;
        end
        else
        begin
            dim_eff = dim_raw;
        end
    end

    assign dim_last = CNT_W'(dim_eff - DIM_W'(1));

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                REG_START_X:     cfg_next.start_x    = start_clamped;
                REG_START_Y:     cfg_next.start_y    = start_clamped;
                REG_ROW_STEP_X:  cfg_next.row_step_x = wr_data;
                REG_ROW_STEP_Y:  cfg_next.row_step_y = wr_data;
                REG_COL_STEP_X:  cfg_next.col_step_x = wr_data;
                REG_COL_STEP_Y:  cfg_next.col_step_y = wr_data;
                REG_DEST_WIDTH:  cfg_next.col_last   = dim_last;
                REG_DEST_HEIGHT: cfg_next.row_last   = dim_last;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x    <= '0;
            cfg_reg.start_y    <= '0;
            cfg_reg.row_step_x <= '0;
            cfg_reg.row_step_y <= '0;
            cfg_reg.col_step_x <= ACC_W'(65536);
            cfg_reg.col_step_y <= '0;
            cfg_reg.col_last   <= ColLastRst;
            cfg_reg.row_last   <= RowLastRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/rotation_address_dda_unit.sv
// Rotation address generator: walks a destination raster row by row and, for
// every pixel beat taken on the input, returns one beat with the source pixel
// coordinate (integer part of two 32-bit fixed-point DDAs, FRAC_BITS fraction
// bits) plus the destination column/row and end-of-row/end-of-frame flags.
// One beat per clock is sustained: the DDA state advances by one add at each
// accepted beat and the result lands in an output register, so the input is
// stalled only while that register holds a beat the sink has not taken.
// Registers are written through the cfg port (always ready); the user must
// write them only while the unit is idle, which the unit does not enforce. A
// new start point applies at the next restart or frame wrap.
module rotation_address_dda_unit
    import rad_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAX_DIM   = 4096
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [ACC_W-1:0]          cfg_data,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      restart,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] src_x,
    output logic signed [COORD_W-1:0] src_y,
    output logic [CNT_W-1:0]          dest_col,
    output logic [CNT_W-1:0]          dest_row,
    output logic                      end_of_row,
    output logic                      end_of_frame
);

    cfg_t cfg;

    logic [ACC_W-1:0] row_x_reg, row_x_next, row_y_reg, row_y_next;
    logic [ACC_W-1:0] pix_x_reg, pix_x_next, pix_y_reg, pix_y_next;
    logic [CNT_W-1:0] col_reg, col_next, row_reg, row_next;

    logic [ACC_W-1:0] row_x_cur, row_y_cur, pix_x_cur, pix_y_cur;
    logic [CNT_W-1:0] col_cur, row_cur;
    logic             eor, eof;
    logic             accept;

    logic signed [ACC_W-1:0] shift_x, shift_y;

    logic                      out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0] src_x_reg, src_y_reg;
    logic [CNT_W-1:0]          dest_col_reg, dest_row_reg;
    logic                      eor_reg, eof_reg;

    rad_cfg_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // Restart reloads the frame origin before this beat is computed
    always_comb
    begin
        if (restart)
        begin
            row_x_cur = cfg.start_x;
            row_y_cur = cfg.start_y;
            pix_x_cur = cfg.start_x;
            pix_y_cur = cfg.start_y;
            col_cur   = '0;
            row_cur   = '0;
        end
        else
        begin
            row_x_cur = row_x_reg;
            row_y_cur = row_y_reg;
            pix_x_cur = pix_x_reg;
            pix_y_cur = pix_y_reg;
            col_cur   = col_reg;
            row_cur   = row_reg;
        end
    end

    assign eor = (col_cur >= cfg.col_last);
    assign eof = eor & (row_cur >= cfg.row_last);

    assign shift_x = $signed(pix_x_cur) >>> FRAC_BITS;
    assign shift_y = $signed(pix_y_cur) >>> FRAC_BITS;

    always_comb
    begin
        row_x_next = row_x_reg;
        row_y_next = row_y_reg;
        pix_x_next = pix_x_reg;
        pix_y_next = pix_y_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (accept)
        begin
            if (eof)
            begin
                row_x_next = cfg.start_x;
                row_y_next = cfg.start_y;
                pix_x_next = cfg.start_x;
                pix_y_next = cfg.start_y;
                col_next   = '0;
                row_next   = '0;
            end
            else if (eor)
            begin
                row_x_next = row_x_cur + cfg.row_step_x;
                row_y_next = row_y_cur + cfg.row_step_y;
                pix_x_next = row_x_cur + cfg.row_step_x;
                pix_y_next = row_y_cur + cfg.row_step_y;
                col_next   = '0;
                row_next   = row_cur + CNT_W'(1);
            end
            else
            begin
                row_x_next = row_x_cur;
                row_y_next = row_y_cur;
                pix_x_next = pix_x_cur + cfg.col_step_x;
                pix_y_next = pix_y_cur + cfg.col_step_y;
                col_next   = col_cur + CNT_W'(1);
                row_next   = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg <= '0;
            row_y_reg <= '0;
            pix_x_reg <= '0;
            pix_y_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            row_x_reg <= row_x_next;
            row_y_reg <= row_y_next;
            pix_x_reg <= pix_x_next;
            pix_y_reg <= pix_y_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // Output beat: hold while stalled, load on every accepted input beat
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_x_reg    <= shift_x[COORD_W-1:0];
            src_y_reg    <= shift_y[COORD_W-1:0];
            dest_col_reg <= col_cur;
            dest_row_reg <= row_cur;
            eor_reg      <= eor;
            eof_reg      <= eof;
        end
    end

    assign out_valid    = out_valid_reg;
    assign src_x        = src_x_reg;
    assign src_y        = src_y_reg;
    assign dest_col     = dest_col_reg;
    assign dest_row     = dest_row_reg;
    assign end_of_row   = eor_reg;
    assign end_of_frame = eof_reg;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import rad_pkg::*;
();

    localparam int FRAC_BITS = 16;
    localparam int MAX_DIM   = 4096;

    typedef struct {
        logic signed [COORD_W-1:0] src_x;
        logic signed [COORD_W-1:0] src_y;
        logic [CNT_W-1:0]          dest_col;
        logic [CNT_W-1:0]          dest_row;
        logic                      end_of_row;
        logic                      end_of_frame;
    } pixel_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [IDX_W-1:0]          cfg_index = '0;
    logic [ACC_W-1:0]          cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic                      restart   = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic [CNT_W-1:0]          dest_col;
    logic [CNT_W-1:0]          dest_row;
    logic                      end_of_row;
    logic                      end_of_frame;

    rotation_address_dda_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .src_x        (src_x),
        .src_y        (src_y),
        .dest_col     (dest_col),
        .dest_row     (dest_row),
        .end_of_row   (end_of_row),
        .end_of_frame (end_of_frame)
    );

    // raster model: settings and DDA state
    logic [ACC_W-1:0] set_start_x, set_start_y;
    logic [ACC_W-1:0] set_row_step_x, set_row_step_y;
    logic [ACC_W-1:0] set_col_step_x, set_col_step_y;
    logic [DIM_W-1:0] set_width, set_height;
    logic [ACC_W-1:0] row_x, row_y, pix_x, pix_y;
    logic [CNT_W-1:0] col_cnt, row_cnt;

    bit     restart_q[$];
    pixel_t pixel_q[$];
    pixel_t want;
    int     n_queued   = 0;
    int     n_accepted = 0;
    int     n_err      = 0;
    int     send_idle  = 9;
    int     recv_idle  = 68;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic logic [COORD_W-1:0] acc_to_coord(input logic [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] shifted;
        shifted = $signed(acc) >>> FRAC_BITS;
        return shifted[COORD_W-1:0];
    endfunction

    task automatic load_frame();
        row_x   = set_start_x[ACC_W-1] ? '0 : set_start_x;
        row_y   = set_start_y[ACC_W-1] ? '0 : set_start_y;
        pix_x   = row_x;
        pix_y   = row_y;
        col_cnt = '0;
        row_cnt = '0;
    endtask

    // compute the beat for one pixel tick, then step the DDAs
    task automatic walk_raster(input logic new_frame);
        int unsigned w, h;
        pixel_t      p;
        w = eff_dim(set_width);
        h = eff_dim(set_height);
        if (new_frame)
            load_frame();
        p.end_of_row   = (col_cnt >= w - 1);
        p.end_of_frame = p.end_of_row && (row_cnt >= h - 1);
        p.src_x        = acc_to_coord(pix_x);
        p.src_y        = acc_to_coord(pix_y);
        p.dest_col     = col_cnt;
        p.dest_row     = row_cnt;
        pixel_q.push_back(p);
        if (p.end_of_frame)
            load_frame();
        else if (p.end_of_row)
        begin
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
            row_x   = row_x + set_row_step_x;
            row_y   = row_y + set_row_step_y;
            pix_x   = row_x;
            pix_y   = row_y;
        end
        else
        begin
            col_cnt = col_cnt + 1'b1;
            pix_x   = pix_x + set_col_step_x;
            pix_y   = pix_y + set_col_step_y;
        end
    endtask

    // driver: hold the beat while stalled, advance on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart  <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                walk_raster(restart);
                n_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (restart_q.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    in_valid <= 1'b1;
                    restart  <= restart_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each accepted beat against the oldest predicted pixel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pixel_q.size() == 0)
                begin
                    $display("%0t: beat with no pixel pending: x=%0d y=%0d col=%0d row=%0d",
                             $time, src_x, src_y, dest_col, dest_row);
                    n_err++;
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (src_x !== want.src_x)
                    begin
                        $display("%0t: src_x expected %0d actual %0d", $time, want.src_x, src_x);
                        n_err++;
                    end
                    if (src_y !== want.src_y)
                    begin
                        $display("%0t: src_y expected %0d actual %0d", $time, want.src_y, src_y);
                        n_err++;
                    end
                    if (dest_col !== want.dest_col)
                    begin
                        $display("%0t: dest_col expected %0d actual %0d",
                                 $time, want.dest_col, dest_col);
                        n_err++;
                    end
                    if (dest_row !== want.dest_row)
                    begin
                        $display("%0t: dest_row expected %0d actual %0d",
                                 $time, want.dest_row, dest_row);
                        n_err++;
                    end
                    if (end_of_row !== want.end_of_row)
                    begin
                        $display("%0t: end_of_row expected %0b actual %0b",
                                 $time, want.end_of_row, end_of_row);
                        n_err++;
                    end
                    if (end_of_frame !== want.end_of_frame)
                    begin
                        $display("%0t: end_of_frame expected %0b actual %0b",
                                 $time, want.end_of_frame, end_of_frame);
                        n_err++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [ACC_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_START_X:     set_start_x    = val;
            REG_START_Y:     set_start_y    = val;
            REG_ROW_STEP_X:  set_row_step_x = val;
            REG_ROW_STEP_Y:  set_row_step_y = val;
            REG_COL_STEP_X:  set_col_step_x = val;
            REG_COL_STEP_Y:  set_col_step_y = val;
            REG_DEST_WIDTH:  set_width      = val[DIM_W-1:0];
            REG_DEST_HEIGHT: set_height     = val[DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_pixels(input int n, input bit first_restart);
        for (int i = 0; i < n; i++)
        begin
            restart_q.push_back((i == 0) ? first_restart : 1'b0);
            n_queued++;
        end
    endtask

    // wait until every pixel is taken and checked, then let the pipe settle
    task automatic drain();
        while (n_accepted != n_queued || pixel_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [ACC_W-1:0] pick_word(input bit is_start);
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4:       return $urandom();
            default:
                if (is_start)
                    return $urandom_range(32'h00FF_FFFF) - 32'h0010_0000;
                else
                    return $urandom_range(32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [ACC_W-1:0] pick_size();
        case ($urandom_range(15))
            0:       return 0;
            1:       return MAX_DIM;
            2:       return $urandom_range(MAX_DIM + 1, 8191);
            3:       return $urandom_range(8191);
            default: return $urandom_range(1, 7);
        endcase
    endfunction

    initial
    begin
        set_start_x    = '0;
        set_start_y    = '0;
        set_row_step_x = '0;
        set_row_step_y = '0;
        set_col_step_x = 32'd65536;
        set_col_step_y = '0;
        set_width      = 13'd640;
        set_height     = 13'd480;
        load_frame();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // defaults after reset, then a restart
        push_pixels(2, 1'b0);
        push_pixels(1, 1'b1);
        drain();

        // negative start clamps, extreme steps overflow, small frame wraps
        write_reg(REG_DEST_WIDTH, 3);
        write_reg(REG_DEST_HEIGHT, 2);
        write_reg(REG_START_X, 32'hFFFF_FFFF);
        write_reg(REG_START_Y, 32'h7FFF_FFFF);
        write_reg(REG_ROW_STEP_X, 32'h8000_0000);
        write_reg(REG_ROW_STEP_Y, 32'h7FFF_FFFF);
        write_reg(REG_COL_STEP_X, 32'h7FFF_FFFF);
        write_reg(REG_COL_STEP_Y, 32'h8000_0000);
        push_pixels(8, 1'b1);
        drain();

        // zero sizes count as one; new start applies at the wrap
        write_reg(REG_START_X, 32'h0001_8000);
        write_reg(REG_DEST_WIDTH, 0);
        write_reg(REG_DEST_HEIGHT, 0);
        push_pixels(3, 1'b0);
        drain();

        // oversize counts as the max
        write_reg(REG_DEST_WIDTH, 8191);
        write_reg(REG_DEST_HEIGHT, MAX_DIM);
        push_pixels(2, 1'b1);
        drain();

        // shrink the frame while inside it
        write_reg(REG_DEST_WIDTH, 5);
        write_reg(REG_DEST_HEIGHT, 3);
        push_pixels(3, 1'b1);
        drain();
        write_reg(REG_DEST_WIDTH, 2);
        push_pixels(2, 1'b0);
        drain();
        write_reg(REG_DEST_HEIGHT, 1);
        push_pixels(2, 1'b0);
        drain();

        for (int seg = 0; seg < 15; seg++)
        begin
            if (seg == 5)
            begin
                send_idle = 68;
                recv_idle = 9;
            end
            else if (seg == 10)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_reg(REG_START_X, pick_word(1'b1));
            write_reg(REG_START_Y, pick_word(1'b1));
            write_reg(REG_ROW_STEP_X, pick_word(1'b0));
            write_reg(REG_ROW_STEP_Y, pick_word(1'b0));
            write_reg(REG_COL_STEP_X, pick_word(1'b0));
            write_reg(REG_COL_STEP_Y, pick_word(1'b0));
            write_reg(REG_DEST_WIDTH, pick_size());
            write_reg(REG_DEST_HEIGHT, pick_size());
            for (int i = 0; i < 100; i++)
            begin
                restart_q.push_back($urandom_range(99) < 3);
                n_queued++;
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (n_err == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
